// File: src/brd_pkg.sv
// Shared types and constants of the bounded ring deque.
package brd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned PORT_WORD_W    = 32;
  localparam int unsigned CAP_W          = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ENTRY     = 3'd4
  } status_e;

  // One result as it leaves the controller; the word comes from the store read port.
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    last;
    logic    has_word;
  } rsp_t;

endpackage

// File: src/brd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/brd_ctrl.sv
// Pointer, occupancy and dump sequencing logic of the ring deque.
module brd_ctrl #(
  parameter int unsigned DEPTH = brd_pkg::DEPTH_DEF,
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  brd_pkg::cmd_e            cmd_i,
  input  logic                     cfg_we_i,
  input  logic [brd_pkg::CAP_W-1:0] cfg_wdata_i,
  output logic                     busy_o,
  output brd_pkg::rsp_t            rsp_o,
  output logic                     ram_we_o,
  output logic [IW-1:0]            ram_waddr_o,
  output logic [IW-1:0]            ram_raddr_o
);

  logic [brd_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic [IW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]             occ_q, occ_d;
  logic                      dump_active_q, dump_active_d;
  logic [IW-1:0]             dump_pos_q, dump_pos_d;
  logic [CW-1:0]             dump_left_q, dump_left_d;
  brd_pkg::rsp_t             rsp_q, rsp_d;
  logic [CW-1:0]             eff_cap;

  // Advance one place, wrapping at the capacity in use.
  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(idx) + CW'(1);
    return (inc == cap) ? '0 : IW'(inc);
  endfunction

  // Step back one place, wrapping at the capacity in use.
  function automatic logic [IW-1:0] prev_idx(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] top;
    top = cap - CW'(1);
    return (idx == '0) ? IW'(top) : idx - IW'(1);
  endfunction

  // Capacities above the store depth act as the depth.
  always_comb begin
    if (32'(capacity_q) > DEPTH) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity_q);
    end
  end

  always_comb begin
    capacity_d    = capacity_q;
    head_d        = head_q;
    tail_d        = tail_q;
    occ_d         = occ_q;
    dump_active_d = dump_active_q;
    dump_pos_d    = dump_pos_q;
    dump_left_d   = dump_left_q;
    rsp_d         = '0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = '0;
    ram_raddr_o   = '0;

    if (dump_active_q) begin
      ram_raddr_o    = dump_pos_q;
      rsp_d.valid    = 1'b1;
      rsp_d.status   = brd_pkg::ST_ENTRY;
      rsp_d.has_word = 1'b1;
      rsp_d.last     = (dump_left_q == CW'(1));
      dump_pos_d     = next_idx(dump_pos_q, eff_cap);
      dump_left_d    = dump_left_q - CW'(1);
      if (dump_left_q == CW'(1)) begin
        dump_active_d = 1'b0;
      end
    end else if (start_i) begin
      unique case (cmd_i)
        brd_pkg::CMD_PUSH_BACK, brd_pkg::CMD_PUSH_FRONT: begin
          rsp_d.valid = 1'b1;
          rsp_d.last  = 1'b1;
          if (occ_q >= eff_cap) begin
            rsp_d.status = brd_pkg::ST_OVERFLOW;
          end else begin
            rsp_d.status = brd_pkg::ST_OK;
            ram_we_o     = 1'b1;
            occ_d        = occ_q + CW'(1);
            if (occ_q == '0) begin
              head_d      = '0;
              tail_d      = '0;
              ram_waddr_o = '0;
            end else if (cmd_i == brd_pkg::CMD_PUSH_BACK) begin
              tail_d      = next_idx(tail_q, eff_cap);
              ram_waddr_o = tail_d;
            end else begin
              head_d      = prev_idx(head_q, eff_cap);
              ram_waddr_o = head_d;
            end
          end
        end
        brd_pkg::CMD_POP_BACK, brd_pkg::CMD_POP_FRONT: begin
          rsp_d.valid = 1'b1;
          rsp_d.last  = 1'b1;
          if (occ_q == '0 || eff_cap == '0) begin
            rsp_d.status = brd_pkg::ST_UNDERFLOW;
          end else begin
            rsp_d.status   = brd_pkg::ST_OK;
            rsp_d.has_word = 1'b1;
            occ_d          = occ_q - CW'(1);
            if (cmd_i == brd_pkg::CMD_POP_BACK) begin
              ram_raddr_o = tail_q;
              tail_d      = prev_idx(tail_q, eff_cap);
            end else begin
              ram_raddr_o = head_q;
              head_d      = next_idx(head_q, eff_cap);
            end
            // last entry gone: park both pointers at the origin
            if (occ_q == CW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        brd_pkg::CMD_DUMP: begin
          rsp_d.valid = 1'b1;
          if (occ_q == '0 || eff_cap == '0) begin
            rsp_d.status = brd_pkg::ST_EMPTY;
            rsp_d.last   = 1'b1;
          end else begin
            ram_raddr_o    = head_q;
            rsp_d.status   = brd_pkg::ST_ENTRY;
            rsp_d.has_word = 1'b1;
            rsp_d.last     = (occ_q == CW'(1));
            if (occ_q != CW'(1)) begin
              dump_active_d = 1'b1;
              dump_pos_d    = next_idx(head_q, eff_cap);
              dump_left_d   = occ_q - CW'(1);
            end
          end
        end
        default: begin
          rsp_d = '0;
        end
      endcase
    end

    // A capacity write builds a fresh, empty deque.
    if (cfg_we_i) begin
      capacity_d = cfg_wdata_i;
      head_d     = '0;
      tail_d     = '0;
      occ_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q    <= brd_pkg::CAP_RESET;
      head_q        <= '0;
      tail_q        <= '0;
      occ_q         <= '0;
      dump_active_q <= 1'b0;
      dump_pos_q    <= '0;
      dump_left_q   <= '0;
      rsp_q         <= '0;
    end else begin
      capacity_q    <= capacity_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      occ_q         <= occ_d;
      dump_active_q <= dump_active_d;
      dump_pos_q    <= dump_pos_d;
      dump_left_q   <= dump_left_d;
      rsp_q         <= rsp_d;
    end
  end

  assign busy_o = dump_active_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_occ_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= eff_cap)
    else $error("occupancy exceeds capacity");

  a_empty_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == '0 |-> head_q == '0 && tail_q == '0)
    else $error("empty deque with pointers away from origin");

  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_active_q |-> dump_left_q != '0 && dump_left_q < occ_q)
    else $error("dump counter out of range");

  a_no_write_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_active_q |-> !ram_we_o)
    else $error("store written during a dump");

  a_dump_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_active_q |=> rsp_q.valid && rsp_q.status == brd_pkg::ST_ENTRY)
    else $error("dump cycle without an entry result");
`endif

endmodule

// File: src/bounded_ring_deque_unit.sv
// Top level of the bounded ring deque: store, controller and result port.
//
// One request per command. Push and pop requests are taken every cycle while
// busy_o is low and answer in the cycle after acceptance with a single strobed
// result. A dump of n entries reads the store one entry per cycle: it holds
// busy_o high while the later entries are read and emits n results on
// consecutive cycles, the first in the cycle after acceptance, the final one
// flagged by last_o. The dump rate is set by the single read port of the store.
// The receiver cannot stall; each result is valid for exactly one cycle with
// done_o. Writing the capacity empties the deque; write it only while idle.
module bounded_ring_deque_unit #(
  parameter int unsigned DEPTH      = brd_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = brd_pkg::WORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [brd_pkg::CMD_W-1:0]          cmd_i,
  input  logic [brd_pkg::PORT_WORD_W-1:0]    push_word_i,
  input  logic                               cfg_we_i,
  input  logic [brd_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic [brd_pkg::STATUS_W-1:0]       status_o,
  output logic [brd_pkg::PORT_WORD_W-1:0]    out_word_o,
  output logic                               last_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = brd_pkg::PORT_WORD_W;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0]   ram_wdata, ram_rdata;
  logic [PW-1:0]           rd_word;
  brd_pkg::rsp_t           rsp;

  brd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (brd_pkg::cmd_e'(cmd_i)),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy_o),
    .rsp_o       (rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr)
  );

  brd_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fit the stored word width to the fixed port width.
  if (WORD_WIDTH > PW) begin : g_wide
    assign ram_wdata = {{(WORD_WIDTH - PW){1'b0}}, push_word_i};
    assign rd_word   = ram_rdata[PW-1:0];
  end else if (WORD_WIDTH < PW) begin : g_narrow
    assign ram_wdata = push_word_i[WORD_WIDTH-1:0];
    assign rd_word   = {{(PW - WORD_WIDTH){1'b0}}, ram_rdata};
  end else begin : g_equal
    assign ram_wdata = push_word_i;
    assign rd_word   = ram_rdata;
  end

  assign done_o     = rsp.valid;
  assign status_o   = rsp.status;
  assign last_o     = rsp.last;
  assign out_word_o = rsp.has_word ? rd_word : '0;

endmodule

// File: tb/bounded_ring_deque_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the bounded ring deque unit with a built-in deque predictor.
module bounded_ring_deque_unit_tb;

  localparam int unsigned RING_DEPTH    = 16;
  localparam int unsigned RING_IW       = $clog2(RING_DEPTH);
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 24;
  localparam int unsigned MAX_GAP       = 17;
  localparam int unsigned PHASE_ITEMS   = 32;
  localparam logic [brd_pkg::CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [brd_pkg::CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [brd_pkg::CMD_W-1:0] CMD_RSVD_HI  = 3'd7;
  localparam logic [brd_pkg::PORT_WORD_W-1:0] WORD_ZERO = '0;
  localparam logic [brd_pkg::PORT_WORD_W-1:0] WORD_ONES = '1;

  typedef struct {
    brd_pkg::status_e                status;
    logic [brd_pkg::PORT_WORD_W-1:0] word;
    logic                            last;
  } outcome_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            start_i     = 1'b0;
  logic [brd_pkg::CMD_W-1:0]       cmd_i       = brd_pkg::CMD_PUSH_BACK;
  logic [brd_pkg::PORT_WORD_W-1:0] push_word_i = '0;
  logic                            cfg_we_i    = 1'b0;
  logic [brd_pkg::CAP_W-1:0]       cfg_wdata_i = '0;
  logic                            busy_o;
  logic                            done_o;
  logic [brd_pkg::STATUS_W-1:0]    status_o;
  logic [brd_pkg::PORT_WORD_W-1:0] out_word_o;
  logic                            last_o;

  // Predicted deque state
  logic [brd_pkg::PORT_WORD_W-1:0] ring_words [RING_DEPTH];
  int unsigned ring_head     = 0;
  int unsigned ring_tail     = 0;
  int unsigned ring_count    = 0;
  int unsigned ring_capacity = brd_pkg::CAP_RESET;

  outcome_t    pending_outcomes [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  always #2 clk_i = ~clk_i;

  bounded_ring_deque_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .push_word_i (push_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_word_o  (out_word_o),
    .last_o      (last_o)
  );

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void expect_outcome(brd_pkg::status_e st,
                                         logic [brd_pkg::PORT_WORD_W-1:0] w, logic l);
    outcome_t o;
    o.status = st;
    o.word   = w;
    o.last   = l;
    pending_outcomes = {pending_outcomes, o};
  endfunction

  function automatic int unsigned usable_capacity();
    return (ring_capacity > RING_DEPTH) ? RING_DEPTH : ring_capacity;
  endfunction

  // Advance the predicted deque by one accepted request and queue what it yields.
  function automatic void apply_command(logic [brd_pkg::CMD_W-1:0] cmd,
                                        logic [brd_pkg::PORT_WORD_W-1:0] word);
    int unsigned cap;
    logic [brd_pkg::PORT_WORD_W-1:0] popped;
    cap = usable_capacity();
    case (cmd)
      brd_pkg::CMD_PUSH_BACK, brd_pkg::CMD_PUSH_FRONT: begin
        if (ring_count >= cap) begin
          expect_outcome(brd_pkg::ST_OVERFLOW, WORD_ZERO, 1'b1);
        end else begin
          if (ring_count == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end else if (cmd == brd_pkg::CMD_PUSH_BACK) begin
            ring_tail = (ring_tail + 1) % cap;
          end else begin
            ring_head = (ring_head + cap - 1) % cap;
          end
          if (cmd == brd_pkg::CMD_PUSH_BACK) ring_words[RING_IW'(ring_tail)] = word;
          else ring_words[RING_IW'(ring_head)] = word;
          ring_count++;
          expect_outcome(brd_pkg::ST_OK, WORD_ZERO, 1'b1);
        end
      end
      brd_pkg::CMD_POP_BACK, brd_pkg::CMD_POP_FRONT: begin
        if (ring_count == 0 || cap == 0) begin
          expect_outcome(brd_pkg::ST_UNDERFLOW, WORD_ZERO, 1'b1);
        end else begin
          if (cmd == brd_pkg::CMD_POP_BACK) begin
            popped = ring_words[RING_IW'(ring_tail)];
            if (ring_count > 1) ring_tail = (ring_tail + cap - 1) % cap;
          end else begin
            popped = ring_words[RING_IW'(ring_head)];
            if (ring_count > 1) ring_head = (ring_head + 1) % cap;
          end
          ring_count--;
          if (ring_count == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end
          expect_outcome(brd_pkg::ST_OK, popped, 1'b1);
        end
      end
      brd_pkg::CMD_DUMP: begin
        if (ring_count == 0 || cap == 0) begin
          expect_outcome(brd_pkg::ST_EMPTY, WORD_ZERO, 1'b1);
        end else begin
          for (int unsigned i = 0; i < ring_count; i++) begin
            expect_outcome(brd_pkg::ST_ENTRY, ring_words[RING_IW'((ring_head + i) % cap)],
                           i + 1 == ring_count);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Call at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(logic [brd_pkg::CMD_W-1:0] cmd,
                              logic [brd_pkg::PORT_WORD_W-1:0] word);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    push_word_i <= word;
    do @(posedge clk_i); while (busy_o);
    apply_command(cmd, word);
  endtask

  // Hold off until every queued result has arrived.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  task automatic write_capacity(logic [brd_pkg::CAP_W-1:0] cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ring_capacity = cap;
    ring_head     = 0;
    ring_tail     = 0;
    ring_count    = 0;
  endtask

  task automatic test_push_pop_ends();
    send_request(brd_pkg::CMD_PUSH_BACK, WORD_ZERO);
    send_request(brd_pkg::CMD_PUSH_FRONT, WORD_ONES);
    send_request(brd_pkg::CMD_PUSH_BACK, 32'hA5A5_5A5A);
    send_request(brd_pkg::CMD_DUMP, WORD_ZERO);
    send_request(brd_pkg::CMD_POP_BACK, WORD_ONES);
    send_request(brd_pkg::CMD_POP_FRONT, WORD_ZERO);
    send_request(brd_pkg::CMD_POP_FRONT, WORD_ZERO);
    send_request(brd_pkg::CMD_POP_BACK, WORD_ZERO);
    send_request(brd_pkg::CMD_DUMP, WORD_ONES);
    send_request(brd_pkg::CMD_PUSH_FRONT, 32'h5A5A_A5A5);
    send_request(brd_pkg::CMD_POP_BACK, WORD_ZERO);
  endtask

  task automatic test_reserved_commands();
    send_request(CMD_RSVD_LO, WORD_ONES);
    send_request(brd_pkg::CMD_PUSH_BACK, 32'h1234_5678);
    send_request(CMD_RSVD_MID, WORD_ZERO);
    send_request(brd_pkg::CMD_POP_FRONT, WORD_ZERO);
    send_request(CMD_RSVD_HI, WORD_ONES);
    wait_drained();
  endtask

  task automatic test_capacity_extremes();
    write_capacity('0);
    send_request(brd_pkg::CMD_PUSH_BACK, WORD_ONES);
    send_request(brd_pkg::CMD_POP_FRONT, WORD_ZERO);
    send_request(brd_pkg::CMD_DUMP, WORD_ZERO);
    write_capacity(5'd1);
    send_request(brd_pkg::CMD_PUSH_FRONT, 32'hDEAD_BEEF);
    send_request(brd_pkg::CMD_PUSH_BACK, WORD_ONES);
    send_request(brd_pkg::CMD_DUMP, WORD_ZERO);
    send_request(brd_pkg::CMD_POP_BACK, WORD_ZERO);
  endtask

  // Random phases under several capacities, steering between full and empty.
  task automatic test_random_traffic();
    logic [brd_pkg::CAP_W-1:0]       caps [8];
    logic [brd_pkg::CMD_W-1:0]       cmd;
    logic [brd_pkg::PORT_WORD_W-1:0] word;
    int unsigned                     pick;
    bit                              filling;
    caps = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd1, 5'd17, 5'd7, 5'($urandom_range(2, 31))};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      filling = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 14) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 29) == 0) wait_drained();
        if (filling && ring_count >= usable_capacity() && $urandom_range(0, 2) == 0)
          filling = 1'b0;
        else if (!filling && ring_count == 0 && $urandom_range(0, 2) == 0)
          filling = 1'b1;
        else if ($urandom_range(0, 19) == 0)
          filling = !filling;
        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = brd_pkg::CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        else if (pick < 13) cmd = brd_pkg::CMD_DUMP;
        else if (pick < (filling ? 73 : 38))
          cmd = $urandom_range(0, 1) ? brd_pkg::CMD_PUSH_FRONT : brd_pkg::CMD_PUSH_BACK;
        else cmd = $urandom_range(0, 1) ? brd_pkg::CMD_POP_FRONT : brd_pkg::CMD_POP_BACK;
        case ($urandom_range(0, 15))
          0:       word = WORD_ZERO;
          1:       word = WORD_ONES;
          default: word = $urandom;
        endcase
        send_request(cmd, word);
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (done_o) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d word %h last %b",
                                    status_o, out_word_o, last_o));
        end else begin
          want = pending_outcomes[0];
          pending_outcomes.delete(0);
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (out_word_o !== want.word)
            report_mismatch($sformatf("out_word %h, want %h", out_word_o, want.word));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %b, want %b", last_o, want.last));
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout after %0d quiet cycles", QUIET_LIMIT);
    $display("bounded_ring_deque_unit test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_push_pop_ends();
    test_reserved_commands();
    test_capacity_extremes();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    if (error_count == 0) begin
      $display("bounded_ring_deque_unit test passed");
    end else begin
      $display("bounded_ring_deque_unit test failed");
    end
    $finish;
  end

endmodule
